// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the terminal writer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TMTW_ASSERT_SAME(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TMTW_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: design/tmtw_pkg.sv
// ---------------------------------------------------------------------------
// tmtw_pkg
// Types and constants of the text-mode terminal writer.
// ---------------------------------------------------------------------------
package tmtw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int LAST    = (ROWS - 1) * COLUMNS;

  // Field widths.
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int ADDR_W = 3;

  // Item selector codes; the last one does nothing but report the cursor.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

  // Register map and reset colour.
  localparam logic REG_TEXT_COLOR = 1'b0;
  localparam logic [7:0] COLOR_RESET = 8'h07;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_COPY,
    ST_FILL
  } state_t;

  // Cursor update commands from the sequencer.
  typedef struct packed {
    logic home;
    logic col_clear;
    logic col_dec;
    logic col_inc;
    logic row_inc;
  } cursor_cmd_t;

  // Cursor status back to the sequencer.
  typedef struct packed {
    logic             last_col;
    logic             last_row;
    logic [POS_W-1:0] pos;
  } cursor_stat_t;

endpackage

// File: design/tmtw_cursor.sv
// ---------------------------------------------------------------------------
// tmtw_cursor
// Cursor row, column and row base address, updated by sequencer commands.
// ---------------------------------------------------------------------------
module tmtw_cursor (
  input  logic                  clk,
  input  logic                  rst,
  input  tmtw_pkg::cursor_cmd_t cmd,
  output tmtw_pkg::cursor_stat_t stat
);
  import tmtw_pkg::*;

  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [POS_W-1:0] row_base;

  // Row and row base move together so the linear position needs no multiply.
  always_ff @(posedge clk) begin
    if (rst || cmd.home) begin
      row      <= '0;
      col      <= '0;
      row_base <= '0;
    end else begin
      if (cmd.row_inc) begin
        row      <= row + 1'b1;
        row_base <= row_base + POS_W'(COLUMNS);
      end
      if (cmd.col_clear) begin
        col <= '0;
      end else if (cmd.col_dec && col != '0) begin
        col <= col - 1'b1;
      end else if (cmd.col_inc) begin
        col <= col + 1'b1;
      end
    end
  end

  // Status toward the sequencer.
  assign stat.last_col = (col == COL_W'(COLUMNS - 1));
  assign stat.last_row = (row == ROW_W'(ROWS - 1));
  assign stat.pos      = row_base + POS_W'(col);

endmodule

// File: design/text_mode_terminal_writer_top.sv
// ---------------------------------------------------------------------------
// text_mode_terminal_writer_top
// Text-mode terminal engine: screen store, cursor and a store-walking sequencer.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows for
// one cycle with done high, and cannot be held off. Backspace, return, an
// unused selector, a read outside the screen and a character or newline that
// does not scroll give done the cycle after start. A read inside the screen
// gives done from the read state, since the store read is registered. A
// clear walks all 2000 cells, one write a cycle, and gives done after the
// last write. A scroll copies 1920 cells through the single read and write
// port, then blanks the 80-cell bottom row, and then gives done. After
// reset the store is blanked by the same walk while busy is high;
// configuration writes are taken meanwhile. The cursor position shown with
// done is the position after the item.
// ---------------------------------------------------------------------------
module text_mode_terminal_writer_top (
  input  logic                          clk,
  input  logic                          rst,
  // Command channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [tmtw_pkg::FUNC_W-1:0]   func,
  input  logic [tmtw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tmtw_pkg::POS_W-1:0]    cell_index,
  // Result channel.
  output logic                          done,
  output logic [tmtw_pkg::POS_W-1:0]    cursor_pos,
  output logic [tmtw_pkg::CELL_W-1:0]   cell_data,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmtw_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tmtw_pkg::*;

  state_t state, state_next;
  logic [POS_W-1:0]  walk, walk_next;
  logic              pend, pend_next;
  logic [POS_W-1:0]  pend_addr, pend_addr_next;
  logic              done_next;
  logic [CELL_W-1:0] cell_data_next;
  logic [7:0]        text_color;

  // Store port controls.
  logic              mem_we;
  logic [POS_W-1:0]  mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              rd_en;
  logic [POS_W-1:0]  rd_addr;
  logic [CELL_W-1:0] rd_data;
  logic [CELL_W-1:0] mem [CELLS];

  cursor_cmd_t  cmd;
  cursor_stat_t stat;

  logic accept;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= COLOR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TEXT_COLOR) begin
      text_color <= pwdata[7:0];
    end
  end
  assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, text_color} : 32'd0;

  // Cursor tracking.
  tmtw_cursor u_cursor (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  // Screen store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign accept = start && !busy;

  // State and walk registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      walk  <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      walk  <= walk_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  // Result payload and pending copy address.
  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    cell_data <= cell_data_next;
  end

  assign busy       = (state != ST_IDLE);
  assign cursor_pos = stat.pos;

  // Sequencer: next state, store port and cursor commands.
  always_comb begin
    state_next     = state;
    walk_next      = walk;
    pend_next      = 1'b0;
    pend_addr_next = walk;
    done_next      = 1'b0;
    cell_data_next = '0;
    mem_we         = 1'b0;
    mem_waddr      = walk;
    mem_wdata      = {text_color, CH_BLANK};
    rd_en          = 1'b0;
    rd_addr        = walk + POS_W'(COLUMNS);
    cmd            = '0;

    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {COLOR_RESET, CH_BLANK};
        if (walk == POS_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
          walk_next  = '0;
        end else begin
          walk_next = walk + 1'b1;
        end
      end

      ST_IDLE: begin
        walk_next = '0;
        if (accept) begin
          case (func)
            FUNC_PUT: begin
              done_next = 1'b1;
              if (char_code == CH_RETURN) begin
                cmd.col_clear = 1'b1;
              end else if (char_code == CH_BACKSPACE) begin
                cmd.col_dec = 1'b1;
              end else begin
                if (char_code != CH_NEWLINE) begin
                  mem_we    = 1'b1;
                  mem_waddr = stat.pos;
                  mem_wdata = {text_color, char_code};
                end
                if (char_code == CH_NEWLINE || stat.last_col) begin
                  cmd.col_clear = 1'b1;
                  if (stat.last_row) begin
                    // Past the bottom: scroll before reporting.
                    done_next  = 1'b0;
                    state_next = ST_COPY;
                  end else begin
                    cmd.row_inc = 1'b1;
                  end
                end else begin
                  cmd.col_inc = 1'b1;
                end
              end
            end
            FUNC_CLEAR: begin
              cmd.home   = 1'b1;
              state_next = ST_CLEAR;
            end
            FUNC_READ: begin
              if (cell_index < POS_W'(CELLS)) begin
                rd_en      = 1'b1;
                rd_addr    = cell_index;
                state_next = ST_READ;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        done_next      = 1'b1;
        cell_data_next = rd_data;
        state_next     = ST_IDLE;
      end

      ST_CLEAR: begin
        mem_we = 1'b1;
        if (walk == POS_W'(CELLS - 1)) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          walk_next = walk + 1'b1;
        end
      end

      ST_COPY: begin
        // Read one row down, write the cell read in the previous cycle.
        rd_en     = 1'b1;
        pend_next = 1'b1;
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr;
          mem_wdata = rd_data;
        end
        walk_next = walk + 1'b1;
        if (walk == POS_W'(LAST - 1)) begin
          state_next = ST_FILL;
        end
      end

      ST_FILL: begin
        mem_we = 1'b1;
        if (pend) begin
          // Last copied cell takes the write port first.
          mem_waddr = pend_addr;
          mem_wdata = rd_data;
        end else if (walk == POS_W'(CELLS - 1)) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          walk_next = walk + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/tmtw_checker.sv
// ---------------------------------------------------------------------------
// tmtw_checker
// Port-level checks of the terminal writer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tmtw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [tmtw_pkg::FUNC_W-1:0]   func,
  input logic                          done,
  input logic [tmtw_pkg::POS_W-1:0]    cursor_pos,
  input logic [tmtw_pkg::CELL_W-1:0]   cell_data
);
  import tmtw_pkg::*;

  logic take;
  assign take = start && !busy;

  // A result is only shown once the engine is free again.
  `TMTW_ASSERT_SAME(a_done_not_busy, clk, rst, done, !busy)

  // The cursor never points outside the screen when a result is shown.
  `TMTW_ASSERT_SAME(a_cursor_range, clk, rst, done, cursor_pos < POS_W'(CELLS))

  // A clear walks the store, so the engine stays busy after it.
  `TMTW_ASSERT_NEXT(a_clear_busy, clk, rst, take && func == FUNC_CLEAR, busy && !done)

  // The unused selector reports at once, leaves the cursor and returns zero data.
  `TMTW_ASSERT_NEXT(a_unused_func, clk, rst, take && func == FUNC_UNUSED,
                    done && cell_data == '0 && $stable(cursor_pos))

endmodule

bind text_mode_terminal_writer_top tmtw_checker u_tmtw_checker (.*);

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// Testbench for text_mode_terminal_writer_top
// Drives put, clear, read and unused commands through the start/busy channel
// and checks each done strobe against a cycle-free model of the screen store
// and cursor. The colour register is changed over its APB port between
// phases, only while no result is outstanding.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tmtw_pkg::*;

  // Register address.
  localparam logic [ADDR_W-1:0] ADDR_TEXT_COLOR = ADDR_W'(4 * REG_TEXT_COLOR);

  // Run limits: a very slow correct run stays far below the cycle limit.
  localparam int CYCLE_LIMIT    = 10_000_000;
  localparam int TAIL_CYCLES    = 2100;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 145;

  // Expected result of one transaction.
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] data;
  } term_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   func;
  logic [CHAR_W-1:0]   char_code;
  logic [POS_W-1:0]    cell_index;
  logic                done;
  logic [POS_W-1:0]    cursor_pos;
  logic [CELL_W-1:0]   cell_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Model of the screen, cursor and colour register.
  logic [CELL_W-1:0]   screen_model [CELLS];
  int unsigned         model_row;
  int unsigned         model_col;
  logic [7:0]          model_color;

  term_result_t        expected_results [$];
  term_result_t        front_result;
  int                  error_count;
  int                  cycle_count;
  int                  item_count;
  int                  read_count;
  int                  scroll_count;
  int                  clear_count;
  int                  color_settings;
  bit                  no_idle;

  text_mode_terminal_writer_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .char_code  (char_code),
    .cell_index (cell_index),
    .done       (done),
    .cursor_pos (cursor_pos),
    .cell_data  (cell_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_mode_terminal_writer_top: mismatch");
      $finish;
    end
  end

  // Compare every done strobe with the oldest outstanding transaction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, got pos %0d data %h",
                 $time, cursor_pos, cell_data);
      end else begin
        front_result = expected_results.pop_front();
        if (cursor_pos !== front_result.pos) begin
          error_count++;
          $display("%0t: cursor_pos expected %0d, got %0d",
                   $time, front_result.pos, cursor_pos);
        end
        if (cell_data !== front_result.data) begin
          error_count++;
          $display("%0t: cell_data expected %h, got %h",
                   $time, front_result.data, cell_data);
        end
      end
    end
  end

  // Move the cursor to the next row, scrolling when it leaves the bottom.
  task automatic model_new_line();
    cursor_row_step: begin
      model_row++;
      if (model_row >= ROWS) begin
        for (int i = 0; i < LAST; i++) screen_model[i] = screen_model[i + COLUMNS];
        for (int i = LAST; i < CELLS; i++) screen_model[i] = {model_color, CH_BLANK};
        model_row = ROWS - 1;
        scroll_count++;
      end
      model_col = 0;
    end
  endtask

  // Apply one accepted command to the model and form its result.
  task automatic model_command(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                               input logic [POS_W-1:0] idx, output term_result_t res);
    res.data = '0;
    case (f)
      FUNC_PUT: begin
        if (ch == CH_NEWLINE) begin
          model_new_line();
        end else if (ch == CH_RETURN) begin
          model_col = 0;
        end else if (ch == CH_BACKSPACE) begin
          if (model_col != 0) model_col--;
        end else begin
          screen_model[model_row * COLUMNS + model_col] = {model_color, ch};
          if (model_col >= COLUMNS - 1) model_new_line();
          else model_col++;
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = {model_color, CH_BLANK};
        model_row = 0;
        model_col = 0;
        clear_count++;
      end
      FUNC_READ: begin
        if (idx < CELLS) res.data = screen_model[idx];
        read_count++;
      end
      default: begin
      end
    endcase
    res.pos = POS_W'(model_row * COLUMNS + model_col);
  endtask

  // Send one command, with random idle cycles in front of it unless no_idle is set.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                           input logic [POS_W-1:0] idx);
    term_result_t res;
    while (!no_idle && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    func       <= f;
    char_code  <= ch;
    cell_index <= idx;
    do @(posedge clk); while (busy);
    model_command(f, ch, idx, res);
    expected_results.push_back(res);
    item_count++;
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write the colour register, then read it back.
  task automatic write_text_color(input logic [7:0] color);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TEXT_COLOR;
    pwdata  <= {24'd0, color};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model_color = color;
    color_settings++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== color) begin
      error_count++;
      $display("%0t: text_color readback expected %h, got %h", $time, color, prdata[7:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random character that is not newline, return or backspace.
  function automatic logic [CHAR_W-1:0] printable_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(255));
    while (c == CH_NEWLINE || c == CH_RETURN || c == CH_BACKSPACE);
    return c;
  endfunction

  // Read right after reset: blank cells, both ends and out-of-range indices, and the unused selector.
  task automatic test_power_up_store();
    send_item(FUNC_READ, 8'h00, 11'd0);
    send_item(FUNC_READ, 8'hFF, POS_W'(CELLS - 1));
    send_item(FUNC_READ, 8'h00, POS_W'(CELLS));
    send_item(FUNC_READ, 8'hFF, 11'h7FF);
    send_item(FUNC_UNUSED, 8'hFF, 11'h7FF);
  endtask

  // Printing, backspace floor, return, newline, unused selector and clear.
  task automatic test_control_codes();
    send_item(FUNC_PUT, 8'h41, 11'd0);
    send_item(FUNC_PUT, 8'h00, 11'h7FF);
    send_item(FUNC_PUT, 8'hFF, 11'd0);
    send_item(FUNC_READ, 8'h00, 11'd0);
    send_item(FUNC_READ, 8'h00, 11'd1);
    send_item(FUNC_READ, 8'h00, 11'd2);
    // The fourth and fifth backspace find the cursor already at column zero.
    repeat (5) send_item(FUNC_PUT, CH_BACKSPACE, 11'd0);
    send_item(FUNC_PUT, 8'h42, 11'd0);
    send_item(FUNC_PUT, 8'h43, 11'd0);
    send_item(FUNC_PUT, CH_RETURN, 11'd0);
    send_item(FUNC_PUT, CH_RETURN, 11'd0);
    send_item(FUNC_PUT, CH_NEWLINE, 11'd0);
    send_item(FUNC_PUT, 8'h7E, 11'd0);
    send_item(FUNC_UNUSED, CH_NEWLINE, 11'd5);
    send_item(FUNC_READ, 8'h00, POS_W'(COLUMNS));
    send_item(FUNC_CLEAR, 8'h41, 11'd3);
    send_item(FUNC_READ, 8'h00, 11'd0);
    send_item(FUNC_READ, 8'h00, POS_W'(COLUMNS));
  endtask

  // Register extremes: written cells and cleared cells take the new colour.
  task automatic test_register_settings();
    logic [7:0] colors [3];
    colors = '{8'h00, 8'hFF, 8'($urandom_range(255))};
    foreach (colors[k]) begin
      wait_for_results();
      write_text_color(colors[k]);
      send_item(FUNC_PUT, 8'h5A, 11'd0);
      send_item(FUNC_READ, 8'h00, 11'd0);
      send_item(FUNC_CLEAR, 8'h00, 11'd0);
      send_item(FUNC_READ, 8'h00, POS_W'(CELLS - 1));
    end
  endtask

  // Fill a whole line, walk to the bottom row and scroll by wrapping there.
  task automatic test_line_wrap_and_scroll();
    send_item(FUNC_CLEAR, 8'h00, 11'd0);
    repeat (COLUMNS) send_item(FUNC_PUT, printable_char(), 11'd0);
    send_item(FUNC_READ, 8'h00, 11'd0);
    send_item(FUNC_READ, 8'h00, POS_W'(COLUMNS - 1));
    send_item(FUNC_READ, 8'h00, POS_W'(COLUMNS));
    repeat (ROWS - 2) send_item(FUNC_PUT, CH_NEWLINE, 11'd0);
    repeat (COLUMNS) send_item(FUNC_PUT, printable_char(), 11'd0);
    send_item(FUNC_READ, 8'h00, POS_W'(LAST - COLUMNS));
    send_item(FUNC_READ, 8'h00, POS_W'(LAST - 1));
    send_item(FUNC_READ, 8'h00, POS_W'(LAST));
    send_item(FUNC_READ, 8'h00, POS_W'(CELLS - 1));
    send_item(FUNC_READ, 8'h00, 11'd0);
    // Change colour so the next scroll fills the bottom row differently.
    wait_for_results();
    write_text_color(8'h1E);
    send_item(FUNC_PUT, CH_NEWLINE, 11'd0);
    send_item(FUNC_READ, 8'h00, POS_W'(LAST));
    send_item(FUNC_READ, 8'h00, POS_W'(LAST - COLUMNS));
  endtask

  // One random command, weighted toward text with reads near the cursor.
  task automatic send_random_item();
    int unsigned pick;
    int          target;
    pick = $urandom_range(999);
    if (pick < 80) begin
      send_item(FUNC_PUT, CH_NEWLINE, POS_W'($urandom_range(2047)));
    end else if (pick < 110) begin
      send_item(FUNC_PUT, CH_RETURN, POS_W'($urandom_range(2047)));
    end else if (pick < 140) begin
      send_item(FUNC_PUT, CH_BACKSPACE, POS_W'($urandom_range(2047)));
    end else if (pick < 145) begin
      send_item(FUNC_CLEAR, CHAR_W'($urandom_range(255)), POS_W'($urandom_range(2047)));
    end else if (pick < 165) begin
      send_item(FUNC_UNUSED, CHAR_W'($urandom_range(255)), POS_W'($urandom_range(2047)));
    end else if (pick < 385) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: begin
          target = int'(model_row * COLUMNS + model_col) + int'($urandom_range(100)) - 80;
          if (target < 0) target = 0;
          if (target > CELLS - 1) target = CELLS - 1;
        end
        7, 8: target = int'($urandom_range(CELLS - 1));
        default: target = int'($urandom_range(2047));
      endcase
      send_item(FUNC_READ, CHAR_W'($urandom_range(255)), POS_W'(target));
    end else begin
      send_item(FUNC_PUT, CHAR_W'($urandom_range(255)), POS_W'($urandom_range(2047)));
    end
  endtask

  // Random text in several colour phases, one phase without idle cycles.
  task automatic test_random_text();
    logic [7:0] color;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      case (phase)
        0: color = 8'h00;
        1: color = 8'hFF;
        default: color = 8'($urandom_range(255));
      endcase
      write_text_color(color);
      no_idle = (phase == 3);
      repeat (PHASE_ITEMS) send_random_item();
    end
    no_idle = 1'b0;
  endtask

  // Main sequence.
  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    func       <= FUNC_PUT;
    char_code  <= '0;
    cell_index <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    error_count    = 0;
    cycle_count    = 0;
    item_count     = 0;
    read_count     = 0;
    scroll_count   = 0;
    clear_count    = 0;
    color_settings = 0;
    no_idle        = 1'b0;
    for (int i = 0; i < CELLS; i++) screen_model[i] = {COLOR_RESET, CH_BLANK};
    model_row   = 0;
    model_col   = 0;
    model_color = COLOR_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_power_up_store();
    test_control_codes();
    test_register_settings();
    test_line_wrap_and_scroll();
    test_random_text();

    // Drain, then give a late or extra strobe time to show up.
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d transactions: %0d reads, %0d scrolls, %0d clears.",
             item_count, read_count, scroll_count, clear_count);
    $display("Colour register set %0d times, with %0d errors.", color_settings, error_count);
    if (error_count == 0) begin
      $display("text_mode_terminal_writer_top: match");
    end else begin
      $display("text_mode_terminal_writer_top: mismatch");
    end
    $finish;
  end

endmodule

// File: text_mode_terminal_writer_top.f
+incdir+design
design/tmtw_pkg.sv
design/tmtw_cursor.sv
design/text_mode_terminal_writer_top.sv
design/tmtw_checker.sv
test/testbench.sv
